FILE: design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared widths, command and register codes, reset values and the control
// structs that pass between the sequencer and its storage blocks.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int MAX_PROCS_DEF = 128;

	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int TIME_W    = 16;
	localparam int CLK_W     = 32;
	localparam int SUM_W     = 39;
	localparam int PIDX_W    = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_LOAD     = 2'd1,
		CMD_DISPATCH = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COST    = 2'd1;

	localparam logic [CFG_W-1:0] QUANTUM_RST = 16'd4;
	localparam logic [CFG_W-1:0] COST_RST    = 16'd0;

	typedef struct packed {
		logic clr;
		logic push;
		logic pop;
	} ring_ctl_t;

	typedef struct packed {
		logic load;
		logic rem_wr;
	} pm_ctl_t;

endpackage

FILE: design/rrs_alu.sv
// ----------------------------------------------------------------------------
// Shared adder/subtractor
// The time arithmetic unit of the scheduler; the sequencer steers its operands
// for clock advance, remaining-time compare, turnaround, waiting and totals.
// ----------------------------------------------------------------------------
module rrs_alu import rrs_pkg::*; (
	input  logic [SUM_W-1:0] a,
	input  logic [SUM_W-1:0] b,
	input  logic             sub,
	output logic [SUM_W-1:0] y
);

	logic [SUM_W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign y     = a + b_eff + SUM_W'(sub);

endmodule

FILE: design/rrs_proc_mem.sv
// ----------------------------------------------------------------------------
// Process record store
// Arrival, burst and remaining-time memories, one write and one registered
// read per cycle each. Entries hold garbage until loaded.
// ----------------------------------------------------------------------------
module rrs_proc_mem import rrs_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	localparam int IDX_W = $clog2(MAX_PROCS)
) (
	input  logic              clk,
	input  pm_ctl_t           ctl,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [TIME_W-1:0] wr_arrival,
	input  logic [TIME_W-1:0] wr_burst,
	input  logic [IDX_W-1:0]  rem_idx,
	input  logic [TIME_W-1:0] rem_data,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [TIME_W-1:0] rd_arrival,
	output logic [TIME_W-1:0] rd_burst,
	output logic [TIME_W-1:0] rd_remaining
);

	logic [TIME_W-1:0] arrival_mem   [MAX_PROCS];
	logic [TIME_W-1:0] burst_mem     [MAX_PROCS];
	logic [TIME_W-1:0] remaining_mem [MAX_PROCS];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			arrival_mem[wr_idx] <= wr_arrival;
			burst_mem[wr_idx]   <= wr_burst;
		end
		rd_arrival <= arrival_mem[rd_idx];
		rd_burst   <= burst_mem[rd_idx];
	end

	// A load seeds the remaining time with the burst; a slice writes it back.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			remaining_mem[wr_idx] <= wr_burst;
		end else if (ctl.rem_wr) begin
			remaining_mem[rem_idx] <= rem_data;
		end
		rd_remaining <= remaining_mem[rd_idx];
	end

endmodule

FILE: design/rrs_ring.sv
// ----------------------------------------------------------------------------
// Ready queue
// Ring of process indexes with head, tail and fill count. The popped index is
// registered onto pop_data in the cycle after the pop.
// ----------------------------------------------------------------------------
module rrs_ring import rrs_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	localparam int IDX_W = $clog2(MAX_PROCS),
	localparam int CNT_W = $clog2(MAX_PROCS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_ctl_t        ctl,
	input  logic [IDX_W-1:0] push_data,
	output logic [IDX_W-1:0] pop_data,
	output logic [CNT_W-1:0] count
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

	logic [IDX_W-1:0] ring_mem [MAX_PROCS];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;

	assign push_ok = ctl.push && (count_q < CNT_W'(MAX_PROCS));
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.clr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_ok) - CNT_W'(ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ring_mem[tail_q] <= push_data;
		end
		if (ctl.pop) begin
			pop_data <= ring_mem[head_q];
		end
	end

endmodule

FILE: design/round_robin_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin CPU scheduler
// Loads process records, then runs the round-robin schedule one time slice
// per dispatch command, reporting completion statistics and running totals.
// ----------------------------------------------------------------------------
// Channel   Handshake               Beat contents
// in        in_valid / in_ready     cmd, arrival_time, burst_time
// out       out_valid / out_ready   proc_index .. all_done (at most one beat per dispatch)
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Clear, load and unused commands leave the block idle. A dispatch holds in_ready
// low while it scans the loaded slots and steps through the slice, with further
// steps when the process finishes; an empty queue adds a search and an admit scan
// and the first dispatch of a job one more scan. Reset clears all control state
// at once; there is no clearing pass. A finished dispatch waits in its last state
// while the previous result beat has not been taken.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler import rrs_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [TIME_W-1:0]    arrival_time,
	input  logic [TIME_W-1:0]    burst_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIDX_W-1:0]    proc_index,
	output logic [CLK_W-1:0]     slice_end_time,
	output logic                 finished,
	output logic [CLK_W-1:0]     turnaround,
	output logic [CLK_W-1:0]     waiting,
	output logic [CLK_W-1:0]     switch_total,
	output logic [SUM_W-1:0]     sum_turnaround,
	output logic [SUM_W-1:0]     sum_waiting,
	output logic                 all_done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_JUMP, S_CHECK, S_POP, S_POPW, S_SW, S_CMP,
		S_ADV, S_TURN, S_WAIT, S_TSUM, S_WSUM, S_PUSH, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		M_START, M_MIN, M_JUMP, M_SLICE
	} scan_mode_t;

	state_t            state_q;
	scan_mode_t        mode_q;
	logic              started_q;
	logic [CNT_W-1:0]  proc_cnt_q;
	logic [CNT_W-1:0]  done_cnt_q;
	logic [CLK_W-1:0]  clock_q;
	logic              last_vld_q;
	logic [IDX_W-1:0]  last_q;
	logic [CLK_W-1:0]  sw_cnt_q;
	logic [SUM_W-1:0]  tsum_q;
	logic [SUM_W-1:0]  wsum_q;
	logic [MAX_PROCS-1:0] queued_q;
	logic [CNT_W-1:0]  scan_k_q;
	logic              scan_vld_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic              any_q;
	logic [TIME_W-1:0] earliest_q;
	logic [IDX_W-1:0]  p_q;
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] burst_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] step_q;
	logic              fin_q;
	logic [CLK_W-1:0]  turn_q;
	logic [CLK_W-1:0]  wait_q;
	logic              res_done_q;
	logic [CFG_W-1:0]  quantum_q;
	logic [CFG_W-1:0]  cost_q;

	logic              out_valid_q;
	logic [PIDX_W-1:0] out_pidx_q;
	logic [CLK_W-1:0]  out_end_q;
	logic              out_fin_q;
	logic [CLK_W-1:0]  out_turn_q;
	logic [CLK_W-1:0]  out_wait_q;
	logic [CLK_W-1:0]  out_sw_q;
	logic [SUM_W-1:0]  out_tsum_q;
	logic [SUM_W-1:0]  out_wsum_q;
	logic              out_done_q;

	logic              in_acc;
	cmd_t              cmd_in;
	ring_ctl_t         ring_ctl;
	logic [IDX_W-1:0]  ring_push_data;
	logic [IDX_W-1:0]  ring_pop_data;
	logic [CNT_W-1:0]  ring_count;
	pm_ctl_t           pm_ctl;
	logic [IDX_W-1:0]  rd_idx;
	logic [TIME_W-1:0] rd_arrival;
	logic [TIME_W-1:0] rd_burst;
	logic [TIME_W-1:0] rd_remaining;
	logic [TIME_W-1:0] rem_wr_data;
	logic [TIME_W-1:0] q_eff;
	logic [SUM_W-1:0]  alu_a;
	logic [SUM_W-1:0]  alu_b;
	logic              alu_sub;
	logic [SUM_W-1:0]  alu_y;
	logic              rem_gt;
	logic              flag_hit;
	logic              admit_hit;
	logic              min_hit;
	logic              scan_end;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign cmd_in    = cmd_t'(cmd);

	assign q_eff = (quantum_q == '0) ? CFG_W'(1) : quantum_q;

	// Scan stage: the arrival read issued last cycle is judged here.
	assign flag_hit  = !queued_q[scan_idx_s1];
	assign admit_hit = flag_hit && (CLK_W'(rd_arrival) <= clock_q);
	assign min_hit   = flag_hit && (!any_q || (rd_arrival < earliest_q));
	assign scan_end  = !scan_vld_s1 && (scan_k_q >= proc_cnt_q);

	// Remaining time exceeds the quantum when the difference neither borrows
	// nor is zero.
	assign rem_gt      = !alu_y[SUM_W-1] && (alu_y != '0);
	assign rem_wr_data = rem_gt ? alu_y[TIME_W-1:0] : '0;

	always_comb begin
		ring_ctl.clr  = in_acc && (cmd_in == CMD_CLEAR);
		ring_ctl.pop  = (state_q == S_POP);
		ring_ctl.push = ((state_q == S_SCAN) && scan_vld_s1 && (mode_q != M_MIN)
			&& admit_hit) || ((state_q == S_PUSH) && !fin_q);
		ring_push_data = (state_q == S_PUSH) ? p_q : scan_idx_s1;

		pm_ctl.load   = in_acc && (cmd_in == CMD_LOAD) && !started_q
			&& (proc_cnt_q < CNT_W'(MAX_PROCS));
		pm_ctl.rem_wr = (state_q == S_CMP);

		if (state_q == S_SCAN) begin
			rd_idx = scan_k_q[IDX_W-1:0];
		end else if (state_q == S_POPW) begin
			rd_idx = ring_pop_data;
		end else begin
			rd_idx = p_q;
		end
	end

	// Operand steering for the shared adder.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_SW: begin
				alu_a = SUM_W'(clock_q);
				alu_b = SUM_W'(cost_q);
			end
			S_CMP: begin
				alu_a   = SUM_W'(rem_q);
				alu_b   = SUM_W'(q_eff);
				alu_sub = 1'b1;
			end
			S_ADV: begin
				alu_a = SUM_W'(clock_q);
				alu_b = SUM_W'(step_q);
			end
			S_TURN: begin
				alu_a   = SUM_W'(clock_q);
				alu_b   = SUM_W'(arr_q);
				alu_sub = 1'b1;
			end
			S_WAIT: begin
				alu_a   = SUM_W'(turn_q);
				alu_b   = SUM_W'(burst_q);
				alu_sub = 1'b1;
			end
			S_TSUM: begin
				alu_a = tsum_q;
				alu_b = SUM_W'(turn_q);
			end
			S_WSUM: begin
				alu_a = wsum_q;
				alu_b = SUM_W'(wait_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	rrs_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	rrs_ring #(.MAX_PROCS(MAX_PROCS)) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.push_data (ring_push_data),
		.pop_data  (ring_pop_data),
		.count     (ring_count)
	);

	rrs_proc_mem #(.MAX_PROCS(MAX_PROCS)) u_proc_mem (
		.clk          (clk),
		.ctl          (pm_ctl),
		.wr_idx       (proc_cnt_q[IDX_W-1:0]),
		.wr_arrival   (arrival_time),
		.wr_burst     (burst_time),
		.rem_idx      (p_q),
		.rem_data     (rem_wr_data),
		.rd_idx       (rd_idx),
		.rd_arrival   (rd_arrival),
		.rd_burst     (rd_burst),
		.rd_remaining (rd_remaining)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_START;
			started_q   <= 1'b0;
			proc_cnt_q  <= '0;
			done_cnt_q  <= '0;
			clock_q     <= '0;
			last_vld_q  <= 1'b0;
			last_q      <= '0;
			sw_cnt_q    <= '0;
			tsum_q      <= '0;
			wsum_q      <= '0;
			queued_q    <= '0;
			scan_k_q    <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			any_q       <= 1'b0;
			earliest_q  <= '0;
			p_q         <= '0;
			arr_q       <= '0;
			burst_q     <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			fin_q       <= 1'b0;
			turn_q      <= '0;
			wait_q      <= '0;
			res_done_q  <= 1'b0;
			quantum_q   <= QUANTUM_RST;
			cost_q      <= COST_RST;
			out_valid_q <= 1'b0;
			out_pidx_q  <= '0;
			out_end_q   <= '0;
			out_fin_q   <= 1'b0;
			out_turn_q  <= '0;
			out_wait_q  <= '0;
			out_sw_q    <= '0;
			out_tsum_q  <= '0;
			out_wsum_q  <= '0;
			out_done_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_QUANTUM) begin
					quantum_q <= cfg_data;
				end else if (cfg_index == CFG_COST) begin
					cost_q <= cfg_data;
				end
			end

			if ((state_q == S_EMIT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_done_q  <= res_done_q;
				out_sw_q    <= sw_cnt_q;
				out_tsum_q  <= tsum_q;
				out_wsum_q  <= wsum_q;
				out_pidx_q  <= res_done_q ? '0 : PIDX_W'(p_q);
				out_end_q   <= res_done_q ? '0 : clock_q;
				out_fin_q   <= !res_done_q && fin_q;
				out_turn_q  <= (!res_done_q && fin_q) ? turn_q : '0;
				out_wait_q  <= (!res_done_q && fin_q) ? wait_q : '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd_in)
							CMD_CLEAR: begin
								started_q  <= 1'b0;
								proc_cnt_q <= '0;
								done_cnt_q <= '0;
								clock_q    <= '0;
								last_vld_q <= 1'b0;
								sw_cnt_q   <= '0;
								tsum_q     <= '0;
								wsum_q     <= '0;
								queued_q   <= '0;
							end
							CMD_LOAD: begin
								if (pm_ctl.load) begin
									proc_cnt_q <= proc_cnt_q + 1'b1;
								end
							end
							CMD_DISPATCH: begin
								if (!started_q) begin
									started_q   <= 1'b1;
									mode_q      <= M_START;
									scan_k_q    <= '0;
									scan_vld_s1 <= 1'b0;
									state_q     <= S_SCAN;
								end else begin
									state_q <= S_CHECK;
								end
							end
							CMD_NONE: begin
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_SCAN: begin
					if (scan_k_q < proc_cnt_q) begin
						scan_k_q    <= scan_k_q + 1'b1;
						scan_vld_s1 <= 1'b1;
						scan_idx_s1 <= scan_k_q[IDX_W-1:0];
					end else begin
						scan_vld_s1 <= 1'b0;
					end
					if (scan_vld_s1) begin
						if (mode_q == M_MIN) begin
							if (min_hit) begin
								any_q      <= 1'b1;
								earliest_q <= rd_arrival;
							end
						end else if (admit_hit) begin
							queued_q[scan_idx_s1] <= 1'b1;
						end
					end
					if (scan_end) begin
						unique case (mode_q)
							M_START: state_q <= S_CHECK;
							M_MIN:   state_q <= S_JUMP;
							M_JUMP:  state_q <= (ring_count == '0) ? S_IDLE : S_POP;
							M_SLICE: state_q <= S_PUSH;
							default: state_q <= S_IDLE;
						endcase
					end
				end

				S_CHECK: begin
					if (done_cnt_q >= proc_cnt_q) begin
						res_done_q <= 1'b1;
						state_q    <= S_EMIT;
					end else if (ring_count == '0) begin
						// Queue empty: find the earliest arrival not yet queued.
						any_q       <= 1'b0;
						earliest_q  <= '0;
						mode_q      <= M_MIN;
						scan_k_q    <= '0;
						scan_vld_s1 <= 1'b0;
						state_q     <= S_SCAN;
					end else begin
						state_q <= S_POP;
					end
				end

				S_JUMP: begin
					if (any_q && (CLK_W'(earliest_q) > clock_q)) begin
						clock_q <= CLK_W'(earliest_q);
					end
					mode_q      <= M_JUMP;
					scan_k_q    <= '0;
					scan_vld_s1 <= 1'b0;
					state_q     <= S_SCAN;
				end

				S_POP: begin
					state_q <= S_POPW;
				end

				S_POPW: begin
					p_q     <= ring_pop_data;
					state_q <= S_SW;
				end

				S_SW: begin
					arr_q   <= rd_arrival;
					burst_q <= rd_burst;
					rem_q   <= rd_remaining;
					if (last_vld_q && (last_q != p_q)) begin
						clock_q  <= alu_y[CLK_W-1:0];
						sw_cnt_q <= sw_cnt_q + 1'b1;
					end
					last_vld_q <= 1'b1;
					last_q     <= p_q;
					state_q    <= S_CMP;
				end

				S_CMP: begin
					fin_q   <= !rem_gt;
					step_q  <= rem_gt ? q_eff : rem_q;
					state_q <= S_ADV;
				end

				S_ADV: begin
					clock_q <= alu_y[CLK_W-1:0];
					if (fin_q) begin
						done_cnt_q <= done_cnt_q + 1'b1;
						state_q    <= S_TURN;
					end else begin
						mode_q      <= M_SLICE;
						scan_k_q    <= '0;
						scan_vld_s1 <= 1'b0;
						state_q     <= S_SCAN;
					end
				end

				S_TURN: begin
					turn_q  <= alu_y[CLK_W-1:0];
					state_q <= S_WAIT;
				end

				S_WAIT: begin
					wait_q  <= alu_y[CLK_W-1:0];
					state_q <= S_TSUM;
				end

				S_TSUM: begin
					tsum_q  <= alu_y;
					state_q <= S_WSUM;
				end

				S_WSUM: begin
					wsum_q      <= alu_y;
					mode_q      <= M_SLICE;
					scan_k_q    <= '0;
					scan_vld_s1 <= 1'b0;
					state_q     <= S_SCAN;
				end

				S_PUSH: begin
					res_done_q <= 1'b0;
					state_q    <= S_EMIT;
				end

				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign proc_index     = out_pidx_q;
	assign slice_end_time = out_end_q;
	assign finished       = out_fin_q;
	assign turnaround     = out_turn_q;
	assign waiting        = out_wait_q;
	assign switch_total   = out_sw_q;
	assign sum_turnaround = out_tsum_q;
	assign sum_waiting    = out_wsum_q;
	assign all_done       = out_done_q;

endmodule

FILE: tb/rrs_slice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler slice checker
// Watches the command, result and register channels of the scheduler. It keeps
// its own copy of the job state and of the two registers, works out the
// result beat, if any, of each accepted dispatch, and compares every result beat field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rrs_slice_checker import rrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [TIME_W-1:0]    arrival_time,
	input  logic [TIME_W-1:0]    burst_time,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [PIDX_W-1:0]    proc_index,
	input  logic [CLK_W-1:0]     slice_end_time,
	input  logic                 finished,
	input  logic [CLK_W-1:0]     turnaround,
	input  logic [CLK_W-1:0]     waiting,
	input  logic [CLK_W-1:0]     switch_total,
	input  logic [SUM_W-1:0]     sum_turnaround,
	input  logic [SUM_W-1:0]     sum_waiting,
	input  logic                 all_done,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam int SLOTS = MAX_PROCS_DEF;

	typedef struct packed {
		logic [PIDX_W-1:0] proc_index;
		logic [CLK_W-1:0]  end_time;
		logic              finished;
		logic [CLK_W-1:0]  turnaround;
		logic [CLK_W-1:0]  waiting;
		logic [CLK_W-1:0]  switches;
		logic [SUM_W-1:0]  turn_sum;
		logic [SUM_W-1:0]  wait_sum;
		logic              all_done;
	} slice_beat_t;

	slice_beat_t slice_q[$];

	logic [CFG_W-1:0]  quantum;
	logic [CFG_W-1:0]  switch_cost;
	logic [TIME_W-1:0] arr_mem[SLOTS];
	logic [TIME_W-1:0] burst_mem[SLOTS];
	logic [TIME_W-1:0] left_mem[SLOTS];
	bit                queued[SLOTS];
	int                ring[SLOTS];
	int                ring_rd;
	int                ring_wr;
	int                in_ring;
	int                loaded;
	int                completed;
	logic [CLK_W-1:0]  now;
	int                prev_proc;
	bit                prev_valid;
	logic [CLK_W-1:0]  switch_cnt;
	logic [SUM_W-1:0]  turn_sum;
	logic [SUM_W-1:0]  wait_sum;
	bit                started;
	int                beats_seen;

	task automatic report_mismatch(string msg);
		$display("%0t ns: result beat %0d: %s", $time, beats_seen, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	task automatic wipe_job();
		for (int k = 0; k < SLOTS; k++) begin
			queued[k] = 1'b0;
		end
		ring_rd    = 0;
		ring_wr    = 0;
		in_ring    = 0;
		loaded     = 0;
		completed  = 0;
		now        = '0;
		prev_proc  = 0;
		prev_valid = 1'b0;
		switch_cnt = '0;
		turn_sum   = '0;
		wait_sum   = '0;
		started    = 1'b0;
	endtask

	task automatic ring_push(int p);
		if (in_ring < SLOTS) begin
			ring[ring_wr] = p;
			ring_wr = (ring_wr + 1) % SLOTS;
			in_ring++;
		end
	endtask

	task automatic queue_arrivals();
		for (int k = 0; k < loaded; k++) begin
			if (!queued[k] && {16'd0, arr_mem[k]} <= now) begin
				queued[k] = 1'b1;
				ring_push(k);
			end
		end
	endtask

	task automatic run_slice(output bit produced, output slice_beat_t beat);
		bit               any;
		bit               fin;
		logic [TIME_W-1:0] earliest;
		logic [CFG_W-1:0]  q_eff;
		logic [TIME_W-1:0] rem;
		logic [CLK_W-1:0]  turn;
		logic [CLK_W-1:0]  idle_time;
		int               p;
		produced  = 1'b0;
		beat      = '0;
		fin       = 1'b0;
		turn      = '0;
		idle_time = '0;
		if (!started) begin
			started = 1'b1;
			queue_arrivals();
		end
		if (completed >= loaded) begin
			beat.switches = switch_cnt;
			beat.turn_sum = turn_sum;
			beat.wait_sum = wait_sum;
			beat.all_done = 1'b1;
			produced = 1'b1;
		end else begin
			// With nothing ready, time skips ahead to the next process to arrive.
			if (in_ring == 0) begin
				any = 1'b0;
				earliest = '0;
				for (int k = 0; k < loaded; k++) begin
					if (!queued[k] && (!any || arr_mem[k] < earliest)) begin
						earliest = arr_mem[k];
						any = 1'b1;
					end
				end
				if (any && {16'd0, earliest} > now) begin
					now = {16'd0, earliest};
				end
				queue_arrivals();
			end
			if (in_ring != 0) begin
				p = ring[ring_rd];
				ring_rd = (ring_rd + 1) % SLOTS;
				in_ring--;
				if (prev_valid && prev_proc != p) begin
					now += CLK_W'(switch_cost);
					switch_cnt++;
				end
				q_eff = (quantum == '0) ? CFG_W'(1) : quantum;
				rem = left_mem[p];
				if (rem > q_eff) begin
					now += CLK_W'(q_eff);
					left_mem[p] = rem - q_eff;
				end else begin
					now += CLK_W'(rem);
					left_mem[p] = '0;
					fin = 1'b1;
					completed++;
					turn = now - {16'd0, arr_mem[p]};
					idle_time = turn - {16'd0, burst_mem[p]};
					turn_sum += SUM_W'(turn);
					wait_sum += SUM_W'(idle_time);
				end
				prev_proc  = p;
				prev_valid = 1'b1;
				// New arrivals go ahead of the process that was just preempted.
				queue_arrivals();
				if (!fin) begin
					ring_push(p);
				end
				beat.proc_index = PIDX_W'(p);
				beat.end_time   = now;
				beat.finished   = fin;
				beat.turnaround = turn;
				beat.waiting    = idle_time;
				beat.switches   = switch_cnt;
				beat.turn_sum   = turn_sum;
				beat.wait_sum   = wait_sum;
				produced = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit          produced;
		slice_beat_t beat;
		if (!arst_n) begin
			quantum     = QUANTUM_RST;
			switch_cost = COST_RST;
			wipe_job();
			slice_q.delete();
			fail_count  = 0;
			beats_seen  = 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (slice_q.size() == 0) begin
					report_mismatch("result beat arrived with no dispatch outstanding");
				end else begin
					beat = slice_q.pop_front();
					check_field("proc_index", 64'(proc_index), 64'(beat.proc_index));
					check_field("slice_end_time", 64'(slice_end_time), 64'(beat.end_time));
					check_field("finished", 64'(finished), 64'(beat.finished));
					check_field("turnaround", 64'(turnaround), 64'(beat.turnaround));
					check_field("waiting", 64'(waiting), 64'(beat.waiting));
					check_field("switch_total", 64'(switch_total), 64'(beat.switches));
					check_field("sum_turnaround", 64'(sum_turnaround), 64'(beat.turn_sum));
					check_field("sum_waiting", 64'(sum_waiting), 64'(beat.wait_sum));
					check_field("all_done", 64'(all_done), 64'(beat.all_done));
				end
				beats_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_QUANTUM) begin
					quantum = cfg_data;
				end else if (cfg_index == CFG_COST) begin
					switch_cost = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				case (cmd_t'(cmd))
					CMD_CLEAR: begin
						wipe_job();
					end
					CMD_LOAD: begin
						if (!started && loaded < SLOTS) begin
							arr_mem[loaded]   = arrival_time;
							burst_mem[loaded] = burst_time;
							left_mem[loaded]  = burst_time;
							loaded++;
						end
					end
					CMD_DISPATCH: begin
						run_slice(produced, beat);
						if (produced) begin
							slice_q.push_back(beat);
						end
					end
					default: begin
					end
				endcase
			end
			pending <= slice_q.size();
		end
	end

endmodule

FILE: tb/round_robin_cpu_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler testbench
// Loads process jobs and dispatches their slices under a range of quantum and
// switch-cost settings, with random gaps on the command side and random stalls
// on the result side. A checker module beside the block predicts and compares
// every result beat; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler_tb;
	import rrs_pkg::*;

	localparam int WORK_ITEMS  = 1800;
	localparam int SETTLE_CYC  = 3 * MAX_PROCS_DEF + 32;
	localparam int STALL_LIMIT = 20000;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_COMB,
		RX_TRICKLE
	} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd;
	logic [TIME_W-1:0]    arrival_time;
	logic [TIME_W-1:0]    burst_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIDX_W-1:0]    proc_index;
	logic [CLK_W-1:0]     slice_end_time;
	logic                 finished;
	logic [CLK_W-1:0]     turnaround;
	logic [CLK_W-1:0]     waiting;
	logic [CLK_W-1:0]     switch_total;
	logic [SUM_W-1:0]     sum_turnaround;
	logic [SUM_W-1:0]     sum_waiting;
	logic                 all_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;

	int                   burst_left;
	int                   work_done;
	logic [CFG_W-1:0]     cur_quantum;

	wire any_beat = (in_valid && in_ready) || (out_valid && out_ready) ||
		(cfg_valid && cfg_ready);

	round_robin_cpu_scheduler dut (.*);

	rrs_slice_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sender: beats go out in bursts of random length with random gaps between.
	task automatic send_item(cmd_t c, logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		cmd          <= c;
		arrival_time <= a;
		burst_time   <= b;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_QUANTUM) begin
			cur_quantum = val;
		end
	endtask

	// A dispatch can end without a beat, so the block gets its full latency
	// after the last outstanding beat before anything else is changed.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic int slices_for(int b, int q);
		return (b == 0) ? 1 : (b + q - 1) / q;
	endfunction

	task automatic run_job();
		int n;
		int q_eff;
		int bmax;
		int amax;
		int need;
		int b;
		q_eff = (cur_quantum == '0) ? 1 : int'(cur_quantum);
		if ($urandom_range(0, 15) == 0) begin
			n = $urandom_range(MAX_PROCS_DEF - 8, MAX_PROCS_DEF + 2);
			bmax = q_eff;
		end else begin
			n = $urandom_range(1, 12);
			bmax = (q_eff >= 16384) ? 65535 : q_eff * 4;
		end
		case ($urandom_range(0, 3))
			0: amax = 0;
			1: amax = 24;
			2: amax = 600;
			default: amax = 65535;
		endcase
		send_item(CMD_CLEAR, TIME_W'($urandom), TIME_W'($urandom));
		work_done++;
		need = 0;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_item(CMD_NONE, TIME_W'($urandom), TIME_W'($urandom));
			end
			b = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, bmax);
			send_item(CMD_LOAD, TIME_W'($urandom_range(0, amax)), TIME_W'(b));
			if (k < MAX_PROCS_DEF) begin
				need += slices_for(b, q_eff);
				work_done++;
			end
		end
		// Mostly run the job to completion, sometimes past it, sometimes cut short.
		case ($urandom_range(0, 9))
			7: need += 1;
			8: need += 2;
			9: need = need / 2;
			default: begin
			end
		endcase
		for (int k = 0; k < need; k++) begin
			send_item(CMD_DISPATCH, TIME_W'($urandom), TIME_W'($urandom));
			work_done++;
			if ($urandom_range(0, 11) == 0) begin
				send_item(CMD_LOAD, TIME_W'($urandom), TIME_W'($urandom));
			end
		end
	endtask

	// Receiver: result stalls follow a pattern that changes every so often.
	initial begin : rx_pattern
		rx_mode_t mode;
		int       span;
		out_ready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(64, 256);
			for (int tick = 0; tick < span; tick++) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:    out_ready <= 1'b1;
					RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
					RX_COMB:    out_ready <= ((tick % 12) >= 5);
					default:    out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || any_beat) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int phase;
		logic [CFG_W-1:0] q;
		logic [CFG_W-1:0] c;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_NONE;
		arrival_time = '0;
		burst_time   = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_QUANTUM;
		cfg_data     = '0;
		burst_left   = 0;
		work_done    = 0;
		cur_quantum  = QUANTUM_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: empty dispatch, unused command, a small job with a
		// zero burst, a preempted process and a jump to a late arrival, then a
		// load after the start and a dispatch once everything is done.
		send_item(CMD_DISPATCH, 16'hffff, 16'hffff);
		send_item(CMD_NONE, 16'hffff, 16'hffff);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000);
		send_item(CMD_LOAD, 16'd0, 16'd0);
		send_item(CMD_LOAD, 16'd2, 16'd9);
		send_item(CMD_LOAD, 16'd0, 16'd4);
		send_item(CMD_LOAD, 16'd40, 16'd3);
		repeat (7) send_item(CMD_DISPATCH, 16'h0000, 16'h0000);
		send_item(CMD_LOAD, 16'd5, 16'd5);
		send_item(CMD_DISPATCH, 16'h0000, 16'h0000);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000);

		// Largest quantum and switch cost with the widest field values.
		settle();
		write_reg(CFG_QUANTUM, 16'hffff);
		write_reg(CFG_COST, 16'hffff);
		send_item(CMD_CLEAR, 16'h0000, 16'h0000);
		send_item(CMD_LOAD, 16'hffff, 16'hffff);
		send_item(CMD_LOAD, 16'h0000, 16'h0001);
		repeat (3) send_item(CMD_DISPATCH, 16'h0000, 16'h0000);

		phase = 0;
		while (work_done < WORK_ITEMS) begin
			settle();
			if (phase == 0) begin
				q = '0;
				c = '0;
			end else begin
				case ($urandom_range(0, 5))
					0: q = '0;
					1: q = 16'd1;
					2: q = CFG_W'($urandom_range(2, 8));
					3: q = CFG_W'($urandom_range(9, 4096));
					4: q = CFG_W'($urandom_range(4097, 65535));
					default: q = 16'hffff;
				endcase
				case ($urandom_range(0, 3))
					0: c = '0;
					1: c = CFG_W'($urandom_range(1, 20));
					2: c = 16'hffff;
					default: c = CFG_W'($urandom_range(0, 65535));
				endcase
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_QUANTUM, q);
				write_reg(CFG_COST, c);
			end else begin
				write_reg(CFG_COST, c);
				write_reg(CFG_QUANTUM, q);
			end
			repeat ($urandom_range(1, 4)) run_job();
			phase++;
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: round_robin_cpu_scheduler.f
design/rrs_pkg.sv
design/rrs_alu.sv
design/rrs_proc_mem.sv
design/rrs_ring.sv
design/round_robin_cpu_scheduler.sv
tb/rrs_slice_checker.sv
tb/round_robin_cpu_scheduler_tb.sv
